// File: rtl/pkr_pkg.sv
// shared types, constants and the acknowledgement text table for the packet receiver
`timescale 1ns / 1ps

package pkr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 9;
  localparam int unsigned SumW      = 16;
  localparam int unsigned HdrBytes  = 3;
  localparam int unsigned SumBytes  = 2;
  localparam int unsigned FirstData = HdrBytes + SumBytes;
  localparam int unsigned TextLen   = 17;
  localparam int unsigned AckLen    = TextLen + 3;
  localparam int unsigned IdxW      = $clog2(AckLen);
  localparam int unsigned TensW     = 5;
  localparam int unsigned UnitsW    = 4;

  localparam logic [ByteW-1:0] StartCharRst = 8'h24;
  localparam logic [ByteW-1:0] NumOffset    = 8'h40;
  localparam logic [ByteW-1:0] LineFeed     = 8'h0A;

  // header positions
  localparam logic [PosW-1:0] PosNumber = 9'd1;
  localparam logic [PosW-1:0] PosLength = 9'd2;
  localparam logic [PosW-1:0] PosSumLo  = 9'd3;
  localparam logic [PosW-1:0] PosSumHi  = 9'd4;

  // ack character slots after the fixed text
  localparam logic [IdxW-1:0] IdxTens  = IdxW'(TextLen);
  localparam logic [IdxW-1:0] IdxUnits = IdxW'(TextLen + 1);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(TextLen + 2);

  // divide by ten through a reciprocal, exact for all 8-bit numbers
  localparam logic [ByteW-1:0] RecipMul   = 8'd205;
  localparam int unsigned      RecipShift = 11;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] number;
  } ack_req_t;

  function automatic logic [ByteW-1:0] ack_text(input logic [IdxW-1:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      5'd0:    ch = 8'h2E;
      5'd1:    ch = 8'h2F;
      5'd2:    ch = 8'h61;
      5'd3:    ch = 8'h76;
      5'd4:    ch = 8'h72;
      5'd5:    ch = 8'h63;
      5'd6:    ch = 8'h61;
      5'd7:    ch = 8'h74;
      5'd8:    ch = 8'h20;
      5'd9:    ch = 8'h63;
      5'd10:   ch = 8'h6F;
      5'd11:   ch = 8'h6E;
      5'd12:   ch = 8'h73;
      5'd13:   ch = 8'h6F;
      5'd14:   ch = 8'h6C;
      5'd15:   ch = 8'h65;
      5'd16:   ch = 8'h20;
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/pkr_frame.sv
// packet framing: header capture, data sum and trailer check
`timescale 1ns / 1ps

module pkr_frame (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [pkr_pkg::ByteW-1:0] rx_byte_i,
  input  logic [pkr_pkg::ByteW-1:0] start_char_i,
  input  logic                   ack_busy_i,
  output logic                   in_stall_o,
  output pkr_pkg::ack_req_t      ack_req_o
);
  import pkr_pkg::*;

  logic             receiving_q, receiving_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] number_q, number_d;
  logic [SumW-1:0]  expected_q, expected_d;
  logic [SumW-1:0]  sum_q, sum_d;
  ack_req_t         req_d;
  logic [PosW-1:0]  end_pos;
  logic             trailer;
  logic             accept;

  assign end_pos = {1'b0, len_q} + PosW'(FirstData);
  assign trailer = receiving_q && (pos_q >= end_pos);

  // hold the trailer back until the previous acknowledgement has gone out
  assign in_stall_o = trailer && ack_busy_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    receiving_d  = receiving_q;
    pos_d        = pos_q;
    len_d        = len_q;
    number_d     = number_q;
    expected_d   = expected_q;
    sum_d        = sum_q;
    req_d.valid  = 1'b0;
    req_d.number = number_q;
    if (accept) begin
      if (receiving_q) begin
        if (pos_q < PosW'(FirstData)) begin
          case (pos_q)
            PosNumber: number_d = rx_byte_i;
            PosLength: len_d = rx_byte_i;
            PosSumLo:  expected_d = {expected_q[SumW-1:ByteW], rx_byte_i};
            PosSumHi:  expected_d = {rx_byte_i, expected_q[ByteW-1:0]};
            default:   ;
          endcase
          pos_d = pos_q + 1'b1;
        end else if (!trailer) begin
          sum_d = sum_q + {{(SumW-ByteW){1'b0}}, rx_byte_i};
          pos_d = pos_q + 1'b1;
        end else begin
          req_d.valid = (sum_q == expected_q);
          sum_d       = '0;
          pos_d       = '0;
          receiving_d = 1'b0;
        end
      end
      // a trailer that equals the start byte re-arms straight away
      if ((rx_byte_i == start_char_i) && (pos_d == '0)) begin
        receiving_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      pos_q       <= '0;
      len_q       <= 8'd128;
      number_q    <= '0;
      expected_q  <= '0;
      sum_q       <= '0;
      ack_req_o   <= '0;
    end else begin
      receiving_q <= receiving_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      number_q    <= number_d;
      expected_q  <= expected_d;
      sum_q       <= sum_d;
      ack_req_o   <= req_d;
    end
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= end_pos || pos_q < PosW'(FirstData))
    else $error("byte position ran past the trailer");

  a_idle_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !receiving_q |-> (pos_q == '0 && sum_q == '0))
    else $error("idle with packet state left over");

  a_req_after_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_req_o.valid |-> $past(trailer && accept))
    else $error("ack request without a trailer word");

endmodule

// File: rtl/pkr_ack.sv
// acknowledgement sequencer with output register
`timescale 1ns / 1ps

module pkr_ack (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pkr_pkg::ack_req_t         ack_req_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [pkr_pkg::ByteW-1:0] tx_char_o,
  output logic                      last_o
);
  import pkr_pkg::*;

  logic                busy_q;
  logic [IdxW-1:0]     idx_q;
  logic [ByteW-1:0]    num_q;
  logic [TensW-1:0]    tens_q;
  logic [UnitsW-1:0]   units;
  logic [SumW-1:0]     recip_prod;
  logic [ByteW-1:0]    tens_x10;
  logic                out_valid_q;
  logic [ByteW-1:0]    char_q, char_d;
  logic                last_q;
  logic                load;

  assign recip_prod = {8'd0, ack_req_i.number} * {8'd0, RecipMul};
  assign tens_x10   = {tens_q, 3'b000} + {2'b00, tens_q, 1'b0};
  assign units      = UnitsW'(num_q - tens_x10);
  assign load       = busy_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (idx_q)
      IdxTens:  char_d = {{(ByteW-TensW){1'b0}}, tens_q} + NumOffset;
      IdxUnits: char_d = {{(ByteW-UnitsW){1'b0}}, units} + NumOffset;
      IdxLast:  char_d = LineFeed;
      default:  char_d = ack_text(idx_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ack_req_i.valid) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == IdxLast) begin
          busy_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_req_i.valid) begin
      num_q  <= ack_req_i.number;
      tens_q <= recip_prod[RecipShift +: TensW];
    end
    if (load) begin
      char_q <= char_d;
      last_q <= (idx_q == IdxLast);
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign tx_char_o   = char_q;
  assign last_o      = last_q;

  a_req_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_req_i.valid |-> !busy_q)
    else $error("ack request while still sending");

  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> char_q == LineFeed)
    else $error("final word is not a line feed");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> out_valid_q && last_q)
    else $error("sequencer stopped before the line feed");

endmodule

// File: rtl/packet_receiver_with_sum_check.sv
// top level of the packet receiver with sum check
`timescale 1ns / 1ps

// Takes one received byte per cycle. A byte equal to the start character arms the
// receiver; then come header byte 0, packet number, length L, checksum low and high,
// L data bytes and a trailer. If the 16-bit sum of the data bytes equals the checksum,
// a 20-word acknowledgement is sent ("./" "avr" "cat console ", tens and units of the
// packet number plus 0x40, line feed with last high), one word per cycle while the
// output is not stalled, after the request has been registered in the framer and the
// sequencer has gone busy; each word is registered at the output. Every byte is taken
// when offered, except that a trailer word is stalled while the acknowledgement
// sequencer is still sending the previous acknowledgement. Start character resets to
// 0x24 and may be written while idle.
module packet_receiver_with_sum_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pkr_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [pkr_pkg::ByteW-1:0] rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [pkr_pkg::ByteW-1:0] tx_char_o,
  output logic                      last_o
);
  import pkr_pkg::*;

  logic [ByteW-1:0] start_char_q;
  ack_req_t         ack_req;
  logic             ack_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= StartCharRst;
    end else if (cfg_we_i) begin
      start_char_q <= cfg_wdata_i;
    end
  end

  pkr_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .rx_byte_i    (rx_byte_i),
    .start_char_i (start_char_q),
    .ack_busy_i   (ack_busy),
    .in_stall_o   (in_stall_o),
    .ack_req_o    (ack_req)
  );

  pkr_ack u_ack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ack_req_i   (ack_req),
    .busy_o      (ack_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_char_o   (tx_char_o),
    .last_o      (last_o)
  );

endmodule
